FILE: rtl/kltv_pkg.sv
// kltv_pkg: shared types and constants of the keyed last-value table
// no dependencies
`timescale 1ns / 1ps

package kltv_pkg;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 144;

   // low 16 bits of the fnv-1a 64 offset basis and prime
   localparam logic [15:0] HASH_BASIS = 16'h2325;
   localparam logic [15:0] HASH_PRIME = 16'h01B3;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_FIND   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_CMP,
      S_FRD,
      S_FRES,
      S_ZERO,
      S_WORD,
      S_RMW,
      S_LAST,
      S_CNT,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      RUN_IDLE,
      RUN_FOUND,
      RUN_NEW,
      RUN_REFUSED
   } run_type;

endpackage

FILE: rtl/keyed_last_value_table_with_diff.sv
// keyed_last_value_table_with_diff: top level, hash, probe and record update
// depends on kltv_pkg and kltv_ram
`timescale 1ns / 1ps

// Last-value table for up to BUCKETS/2 keys (market, six-byte code); BUCKETS
// must be a power of two. The key is hashed with FNV-1a cut to 16 bits, the
// market folded in whole, then one code byte per cycle. Linear probing reads
// the key memory and ends at a free slot, a matching key or after all slots. A
// find then reads its record word and counters and returns them. An update run
// hashes and probes on its first word only; a new key also clears its record of
// 17+4*BOOK_LEVELS words, one word a cycle. Each record word passes S_WORD, then
// S_RMW for a found key (read-compare-write of the single record memory), then
// S_LAST; a run's last word adds S_CNT (counters, skipped if refused) and S_OUT.
// Memories are not cleared after reset; only the valid marks and key total are.

module keyed_last_value_table_with_diff #(
   parameter int BUCKETS     = 64,
   parameter int BOOK_LEVELS = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // market, stock_code, word_index, word_value, zero pad
   input  logic [kltv_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,  // func
   input  logic                              req_tlast,  // run_last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, key_found, change_mask, observations, updates, read_value, zero pad
   output logic [kltv_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import kltv_pkg::*;

   localparam int LOG  = $clog2(BUCKETS);
   localparam int REC  = 17 + 4 * BOOK_LEVELS;
   localparam int RD   = BUCKETS * REC;
   localparam int RA   = $clog2(RD);
   localparam int ZW   = $clog2(REC);
   localparam int TW   = LOG + 1;

   state_type         state_ff, state_in;
   run_type           run_ff, run_in;
   logic              func_ff, func_in;
   logic [15:0]       market_ff, market_in;
   logic [47:0]       code_ff, code_in;
   logic [5:0]        widx_ff, widx_in;
   logic [63:0]       wval_ff, wval_in;
   logic              last_ff, last_in;
   logic [15:0]       hash_ff, hash_in;
   logic [47:0]       code_sh_ff, code_sh_in;
   logic [2:0]        step_ff, step_in;
   logic [LOG-1:0]    idx_ff, idx_in;
   logic [LOG:0]      cnt_ff, cnt_in;
   logic [LOG-1:0]    slot_ff, slot_in;
   logic              found_ff, found_in;
   logic [ZW-1:0]     zero_ff, zero_in;
   logic [LOG-1:0]    run_slot_ff, run_slot_in;
   logic [7:0]        run_mask_ff, run_mask_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [BUCKETS-1:0] valid_ff, valid_in;
   logic              res_status_ff, res_status_in;
   logic              res_found_ff, res_found_in;
   logic [7:0]        res_mask_ff, res_mask_in;
   logic [31:0]       res_obs_ff, res_obs_in;
   logic [31:0]       res_upd_ff, res_upd_in;
   logic [63:0]       res_read_ff, res_read_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              key_we, cnt_we, rec_we;
   logic [LOG-1:0]    key_waddr, cnt_waddr, cnt_raddr;
   logic [63:0]       key_wdata, key_rdata, cnt_wdata, cnt_rdata, rec_wdata, rec_rdata;
   logic [RA-1:0]     rec_waddr, rec_raddr;

   logic              accept, out_free;
   logic [15:0]       hash_mix;
   logic              probe_done, probe_hit, probe_free;
   logic              key_match, w_ok, table_full;
   logic [RA-1:0]     rec_addr_run, rec_addr_find, rec_addr_zero;
   logic [31:0]       obs_inc, upd_inc;

   function automatic logic [7:0] group_mask(input logic [5:0] w);
      logic [7:0] m;
      m = 8'h00;
      priority if (w == 6'd0) m[1] = 1'b1;
      else if (w <= 6'd4) m[2] = 1'b1;
      else if (w == 6'd5) m[3] = 1'b1;
      else if (w <= 6'd7) m[4] = 1'b1;
      else if (w <= 6'd11) m[5] = 1'b1;
      else if (w < 6'(12 + 4 * BOOK_LEVELS)) m[6] = 1'b1;
      else m[7] = 1'b1;
      return m;
   endfunction

   kltv_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(idx_ff), .rd_data(key_rdata)
   );

   kltv_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_cnt_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   kltv_ram #(.WIDTH(64), .DEPTH(RD)) u_rec_ram (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_waddr), .wr_data(rec_wdata),
      .rd_addr(rec_raddr), .rd_data(rec_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign hash_mix   = 16'(hash_ff * HASH_PRIME);
   assign key_match  = (key_rdata == {market_ff, code_ff});
   assign w_ok       = (widx_ff < 6'(REC));
   assign table_full = ({total_ff, 1'b0} >= (TW + 1)'(BUCKETS));
   assign rec_addr_run  = RA'(RA'(run_slot_ff) * RA'(REC)) + RA'(widx_ff);
   assign rec_addr_find = RA'(RA'(slot_ff) * RA'(REC)) + RA'(widx_ff);
   assign rec_addr_zero = RA'(RA'(run_slot_ff) * RA'(REC)) + RA'(zero_ff);
   assign obs_inc = (cnt_rdata[31:0] == 32'hFFFF_FFFF) ? cnt_rdata[31:0]
                                                       : cnt_rdata[31:0] + 32'd1;
   assign upd_inc = (cnt_rdata[63:32] == 32'hFFFF_FFFF) ? cnt_rdata[63:32]
                                                        : cnt_rdata[63:32] + 32'd1;

   // probe outcome
   always_comb begin
      probe_done = 1'b0;
      probe_hit  = 1'b0;
      probe_free = 1'b0;
      if (state_ff == S_PROBE && !valid_ff[idx_ff]) begin
         probe_done = 1'b1;
         probe_free = 1'b1;
      end else if (state_ff == S_CMP) begin
         if (key_match) begin
            probe_done = 1'b1;
            probe_hit  = 1'b1;
         end else if (cnt_ff == (LOG + 1)'(BUCKETS - 1)) begin
            probe_done = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == FUNC_UPDATE && run_ff != RUN_IDLE) state_in = S_WORD;
               else state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (step_ff == 3'd6) state_in = S_PROBE;
         end
         S_PROBE, S_CMP: begin
            if (probe_done) begin
               if (func_ff == FUNC_FIND) state_in = S_FRD;
               else if (probe_hit || !probe_free || table_full) state_in = S_WORD;
               else state_in = S_ZERO;
            end else begin
               state_in = (state_ff == S_PROBE) ? S_CMP : S_PROBE;
            end
         end
         S_FRD:  state_in = S_FRES;
         S_FRES: state_in = S_OUT;
         S_ZERO: begin
            if (zero_ff == ZW'(REC - 1)) state_in = S_WORD;
         end
         S_WORD: begin
            if (run_ff == RUN_FOUND && w_ok) state_in = S_RMW;
            else state_in = S_LAST;
         end
         S_RMW: state_in = S_LAST;
         S_LAST: begin
            if (!last_ff) state_in = S_IDLE;
            else if (run_ff == RUN_REFUSED) state_in = S_OUT;
            else state_in = S_CNT;
         end
         S_CNT: state_in = S_OUT;
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      run_in        = run_ff;
      func_in       = func_ff;
      market_in     = market_ff;
      code_in       = code_ff;
      widx_in       = widx_ff;
      wval_in       = wval_ff;
      last_in       = last_ff;
      hash_in       = hash_ff;
      code_sh_in    = code_sh_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      found_in      = found_ff;
      zero_in       = zero_ff;
      run_slot_in   = run_slot_ff;
      run_mask_in   = run_mask_ff;
      total_in      = total_ff;
      valid_in      = valid_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_mask_in   = res_mask_ff;
      res_obs_in    = res_obs_ff;
      res_upd_in    = res_upd_ff;
      res_read_in   = res_read_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      key_we        = 1'b0;
      key_waddr     = idx_ff;
      key_wdata     = {market_ff, code_ff};
      cnt_we        = 1'b0;
      cnt_waddr     = idx_ff;
      cnt_wdata     = {32'd1, 32'd1};
      cnt_raddr     = (func_ff == FUNC_FIND) ? slot_ff : run_slot_ff;
      rec_we        = 1'b0;
      rec_waddr     = rec_addr_run;
      rec_wdata     = wval_ff;
      rec_raddr     = (func_ff == FUNC_FIND) ? rec_addr_find : rec_addr_run;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in    = req_tuser;
               market_in  = req_tdata[15:0];
               code_in    = req_tdata[63:16];
               widx_in    = req_tdata[69:64];
               wval_in    = req_tdata[133:70];
               last_in    = req_tlast;
               hash_in    = HASH_BASIS ^ req_tdata[15:0];
               code_sh_in = req_tdata[63:16];
               step_in    = 3'd0;
            end
         end
         S_HASH: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               hash_in = hash_mix;
               idx_in  = hash_mix[LOG-1:0];
               cnt_in  = '0;
            end else begin
               hash_in    = hash_mix ^ {8'h00, code_sh_ff[7:0]};
               code_sh_in = {8'h00, code_sh_ff[47:8]};
            end
         end
         S_PROBE, S_CMP: begin
            if (probe_done) begin
               slot_in  = idx_ff;
               found_in = probe_hit;
               if (func_ff == FUNC_UPDATE) begin
                  run_slot_in = idx_ff;
                  zero_in     = '0;
                  if (probe_hit) begin
                     run_in      = RUN_FOUND;
                     run_mask_in = 8'h00;
                  end else if (!probe_free || table_full) begin
                     run_in      = RUN_REFUSED;
                     run_mask_in = 8'h00;
                  end else begin
                     run_in          = RUN_NEW;
                     run_mask_in     = 8'h01;
                     valid_in[idx_ff] = 1'b1;
                     key_we          = 1'b1;
                     cnt_we          = 1'b1;
                     total_in        = total_ff + TW'(1);
                  end
               end
            end else if (state_ff == S_CMP) begin
               idx_in = idx_ff + LOG'(1);
               cnt_in = cnt_ff + (LOG + 1)'(1);
            end
         end
         S_FRD: begin
         end
         S_FRES: begin
            res_status_in = 1'b0;
            res_found_in  = found_ff;
            res_mask_in   = 8'h00;
            res_obs_in    = found_ff ? cnt_rdata[31:0] : 32'd0;
            res_upd_in    = found_ff ? cnt_rdata[63:32] : 32'd0;
            res_read_in   = (found_ff && w_ok) ? rec_rdata : 64'd0;
         end
         S_ZERO: begin
            rec_we    = 1'b1;
            rec_waddr = rec_addr_zero;
            rec_wdata = 64'd0;
            zero_in   = zero_ff + ZW'(1);
         end
         S_WORD: begin
            if (run_ff == RUN_NEW && w_ok) rec_we = 1'b1;
         end
         S_RMW: begin
            rec_we = 1'b1;
            if (rec_rdata != wval_ff) run_mask_in = run_mask_ff | group_mask(widx_ff);
         end
         S_LAST: begin
            if (last_ff && run_ff == RUN_REFUSED) begin
               res_status_in = 1'b1;
               res_found_in  = 1'b0;
               res_mask_in   = 8'h00;
               res_obs_in    = 32'd0;
               res_upd_in    = 32'd0;
               res_read_in   = 64'd0;
               run_in        = RUN_IDLE;
               run_mask_in   = 8'h00;
            end
         end
         S_CNT: begin
            res_status_in = 1'b0;
            res_found_in  = (run_ff == RUN_FOUND);
            res_mask_in   = run_mask_ff;
            res_read_in   = 64'd0;
            res_obs_in    = cnt_rdata[31:0];
            res_upd_in    = cnt_rdata[63:32];
            if (run_ff == RUN_FOUND) begin
               res_obs_in = obs_inc;
               if (run_mask_ff != 8'h00) res_upd_in = upd_inc;
               cnt_we    = 1'b1;
               cnt_waddr = run_slot_ff;
               cnt_wdata = {(run_mask_ff != 8'h00) ? upd_inc : cnt_rdata[63:32], obs_inc};
            end
            run_in      = RUN_IDLE;
            run_mask_in = 8'h00;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = RSP_DATA_W'({res_read_ff, res_upd_ff, res_obs_ff,
                                            res_mask_ff, res_found_ff, res_status_ff});
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         run_ff        <= RUN_IDLE;
         run_slot_ff   <= '0;
         run_mask_ff   <= 8'h00;
         total_ff      <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_ff        <= run_in;
         run_slot_ff   <= run_slot_in;
         run_mask_ff   <= run_mask_in;
         total_ff      <= total_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      market_ff     <= market_in;
      code_ff       <= code_in;
      widx_ff       <= widx_in;
      wval_ff       <= wval_in;
      last_ff       <= last_in;
      hash_ff       <= hash_in;
      code_sh_ff    <= code_sh_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      found_ff      <= found_in;
      zero_ff       <= zero_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_mask_ff   <= res_mask_in;
      res_obs_ff    <= res_obs_in;
      res_upd_ff    <= res_upd_in;
      res_read_ff   <= res_read_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: rtl/kltv_ram.sv
// kltv_ram: generic simple dual-port ram, one write and one registered read
// depends on nothing
`timescale 1ns / 1ps

module kltv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
